// ----- sv/ddwm_pkg.sv -----
// Package for the depth dip waypoint matcher: sizes, register indexes and types shared by
// the scan pipeline and the top level, and the rounding helper of the scan pipeline.
// Depends on nothing.
`default_nettype none
package ddwm_pkg;

	localparam int MAX_ROWS = 32;
	localparam int MAX_COLS = 32;

	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RCNT_W = $clog2(MAX_ROWS + 1);
	localparam int CCNT_W = $clog2(MAX_COLS + 1);

	localparam int COORD_W = 18;
	localparam int RAD_W = 27;
	localparam int STEP_W = 26;
	localparam int GRID_W = 6;
	localparam int CFG_W = 27;
	localparam int IDX_W = 3;
	localparam int POS_W = 5;
	localparam int TOTAL_W = 11;

	localparam int IDXM_W = (ROW_W > COL_W) ? ROW_W : COL_W;
	localparam int PROD_W = STEP_W + IDXM_W + 1;
	localparam int RND_W = PROD_W - 7;
	localparam int WAY_W = RND_W + 1;
	localparam int DIFF_W = WAY_W + 1;
	localparam int SQ_W = 2 * DIFF_W;
	localparam int SUM_W = SQ_W + 1;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	typedef enum logic [IDX_W-1:0] {
		REG_DEPTH_LIMIT = 3'd0,
		REG_RADIUS_SQ   = 3'd1,
		REG_FIRST_X     = 3'd2,
		REG_FIRST_Y     = 3'd3,
		REG_STEP_X      = 3'd4,
		REG_STEP_Y      = 3'd5,
		REG_COLS        = 3'd6,
		REG_ROWS        = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MAP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic signed [STEP_W-1:0]  step_x;
		logic signed [STEP_W-1:0]  step_y;
		logic [RAD_W-1:0]          radius_squared;
		logic [GRID_W-1:0]         cols_in_use;
		logic [GRID_W-1:0]         rows_in_use;
	} geom_t;

	typedef struct packed {
		logic             done;
		logic             found;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} srch_res_t;

	// Divide by 256 and round to nearest, halves away from zero.
	function automatic logic signed [RND_W-1:0] rnd256(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] q;
		mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		q = (mag + PROD_W'(128)) >> 8;
		rnd256 = p[PROD_W-1] ? -$signed(RND_W'(q)) : $signed(RND_W'(q));
	endfunction

endpackage
`default_nettype wire

// ----- sv/ddwm_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none
module ddwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- sv/ddwm_search.sv -----
// Waypoint scan pipeline: walks the grid in serpentine order, one waypoint per cycle,
// and reports the first waypoint within the radius. Depends on ddwm_pkg.
`default_nettype none
module ddwm_search (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic signed [ddwm_pkg::COORD_W-1:0] px,
	input  wire logic signed [ddwm_pkg::COORD_W-1:0] py,
	input  wire ddwm_pkg::geom_t                  geom,
	output ddwm_pkg::srch_res_t                   res
);
	import ddwm_pkg::*;

	function automatic logic [CCNT_W-1:0] clamp_cols(input logic [GRID_W-1:0] v);
		if (v == '0) begin
			clamp_cols = CCNT_W'(1);
		end else if (int'(v) > MAX_COLS) begin
			clamp_cols = CCNT_W'(MAX_COLS);
		end else begin
			clamp_cols = CCNT_W'(v);
		end
	endfunction

	function automatic logic [RCNT_W-1:0] clamp_rows(input logic [GRID_W-1:0] v);
		if (v == '0) begin
			clamp_rows = RCNT_W'(1);
		end else if (int'(v) > MAX_ROWS) begin
			clamp_rows = RCNT_W'(MAX_ROWS);
		end else begin
			clamp_rows = RCNT_W'(v);
		end
	endfunction

	logic [CCNT_W-1:0] cols_n;
	logic [RCNT_W-1:0] rows_n;
	logic              col_end;
	logic              row_end;
	logic [COL_W-1:0]  col_c;
	logic              kill;
	logic              hit;

	logic                      active_q;
	logic [ROW_W-1:0]          i_q;
	logic [COL_W-1:0]          j_q;
	logic signed [COORD_W-1:0] px_q;
	logic signed [COORD_W-1:0] py_q;

	logic                     v_s1, v_s2, v_s3;
	logic                     last_s1, last_s2, last_s3;
	logic [ROW_W-1:0]         row_s1, row_s2, row_s3;
	logic [COL_W-1:0]         col_s1, col_s2, col_s3;
	logic signed [PROD_W-1:0] prod_x_s1, prod_y_s1;
	logic signed [DIFF_W-1:0] dx_s2, dy_s2;
	logic [SQ_W-1:0]          dx2_s3, dy2_s3;

	logic signed [WAY_W-1:0] wx;
	logic signed [WAY_W-1:0] wy;
	logic [SUM_W-1:0]        dist2;

	logic signed [PROD_W-1:0] prod_x, prod_y;
	logic signed [SQ_W-1:0]   dx_sq, dy_sq;

	logic             done_q;
	logic             found_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	assign cols_n = clamp_cols(geom.cols_in_use);
	assign rows_n = clamp_rows(geom.rows_in_use);
	assign col_end = (CCNT_W'(j_q) == cols_n - CCNT_W'(1));
	assign row_end = (RCNT_W'(i_q) == rows_n - RCNT_W'(1));
	assign col_c = i_q[0] ? COL_W'(cols_n - CCNT_W'(1) - CCNT_W'(j_q)) : j_q;

	assign prod_x = PROD_W'($signed({1'b0, col_c})) * PROD_W'(geom.step_x);
	assign prod_y = PROD_W'($signed({1'b0, i_q})) * PROD_W'(geom.step_y);

	assign wx = WAY_W'(geom.first_x) + WAY_W'(rnd256(prod_x_s1));
	assign wy = WAY_W'(geom.first_y) + WAY_W'(rnd256(prod_y_s1));

	assign dx_sq = SQ_W'(dx_s2) * SQ_W'(dx_s2);
	assign dy_sq = SQ_W'(dy_s2) * SQ_W'(dy_s2);

	assign dist2 = SUM_W'(dx2_s3) + SUM_W'(dy2_s3);
	assign hit = (dist2 <= SUM_W'(geom.radius_squared));
	assign kill = v_s3 && (hit || last_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= kill;
			if (start) begin
				active_q <= 1'b1;
				i_q <= '0;
				j_q <= '0;
			end else if (kill) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				if (col_end) begin
					j_q <= '0;
					i_q <= i_q + ROW_W'(1);
					if (row_end) begin
						active_q <= 1'b0;
					end
				end else begin
					j_q <= j_q + COL_W'(1);
				end
			end
			v_s1 <= active_q && !kill && !start;
			v_s2 <= v_s1 && !kill;
			v_s3 <= v_s2 && !kill;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			px_q <= px;
			py_q <= py;
		end
		last_s1 <= col_end && row_end;
		row_s1 <= i_q;
		col_s1 <= col_c;
		prod_x_s1 <= prod_x;
		prod_y_s1 <= prod_y;

		last_s2 <= last_s1;
		row_s2 <= row_s1;
		col_s2 <= col_s1;
		dx_s2 <= DIFF_W'(px_q) - DIFF_W'(wx);
		dy_s2 <= DIFF_W'(py_q) - DIFF_W'(wy);

		last_s3 <= last_s2;
		row_s3 <= row_s2;
		col_s3 <= col_s2;
		dx2_s3 <= $unsigned(dx_sq);
		dy2_s3 <= $unsigned(dy_sq);

		if (kill) begin
			found_q <= hit;
			row_q <= row_s3;
			col_q <= col_s3;
		end
	end

	assign res.done = done_q;
	assign res.found = found_q;
	assign res.row = row_q;
	assign res.col = col_q;

endmodule
`default_nettype wire

// ----- sv/depth_dip_waypoint_matcher_top.sv -----
// Top level of the depth dip waypoint matcher: configuration registers, sequencer,
// matched-waypoint map with its row valid bits, and the output register.
// Depends on ddwm_pkg, ddwm_ram and ddwm_search.
//
//   channel   direction  handshake                     contents
//   s_axis    in         s_axis_tvalid/s_axis_tready   one point a word
//   m_axis    out        m_axis_tvalid/m_axis_tready   one result a word
//   cfg       in         cfg_we                        register index and data
//
// A point that is not problematic goes from acceptance to the final state, where its
// result is loaded into the output register. A problematic point first goes through the
// scan pipeline, which tests up to rows times columns waypoints; a match adds a map read.
// Reset clears the map at once through its row valid bits; no clearing pass is run.
// A new word is taken only while the sequencer is idle; a held result stalls the
// sequencer in its final state until the output register is free.
`default_nettype none
module depth_dip_waypoint_matcher_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// point_x [17:0], point_y [35:18], point_z [53:36], zero [55:54]
	input  wire logic [55:0]                  s_axis_tdata,
	// point_finite [0]
	input  wire logic [0:0]                   s_axis_tuser,
	input  wire logic                         s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// match_row [4:0], match_col [9:5], matched_total [20:10], zero [23:21]
	output logic [23:0]                       m_axis_tdata,
	// problematic [0], match_found [1], newly_matched [2]
	output logic [2:0]                        m_axis_tuser,
	output logic                              m_axis_tlast,
	input  wire logic                         cfg_we,
	input  wire logic [ddwm_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [ddwm_pkg::CFG_W-1:0]   cfg_data
);
	import ddwm_pkg::*;

	logic signed [COORD_W-1:0] depth_limit_q;
	geom_t                     geom_q;

	state_t state_q, state_d;

	logic signed [COORD_W-1:0] in_x, in_y, in_z;
	logic                      in_prob;
	logic                      in_fire;
	logic                      out_free;
	logic                      srch_start;
	logic                      ram_re;
	logic                      out_load;
	srch_res_t                 srch_res;

	logic                 prob_q;
	logic                 last_q;
	logic                 found_q;
	logic                 fresh_q;
	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     col_q;
	logic [TOTAL_W-1:0]   count_q;
	logic [MAX_ROWS-1:0]  row_vld_q;

	logic [MAX_COLS-1:0]  ram_rdata;
	logic [MAX_COLS-1:0]  row_bits;
	logic [MAX_COLS-1:0]  row_new;
	logic                 bit_set;
	logic                 ram_we;

	assign in_x = s_axis_tdata[17:0];
	assign in_y = s_axis_tdata[35:18];
	assign in_z = s_axis_tdata[53:36];
	assign in_prob = s_axis_tuser[0] && (in_z < depth_limit_q);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	assign row_bits = row_vld_q[row_q] ? ram_rdata : '0;
	assign bit_set = row_bits[col_q];
	assign row_new = row_bits | (MAX_COLS'(1) << col_q);
	assign ram_we = (state_q == ST_MAP) && !bit_set;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = in_prob ? ST_SEARCH : ST_FIN;
				end
			end
			ST_SEARCH: begin
				if (srch_res.done) begin
					state_d = srch_res.found ? ST_MAP : ST_FIN;
				end
			end
			ST_MAP: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		srch_start = 1'b0;
		ram_re = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				srch_start = s_axis_tvalid && in_prob;
			end
			ST_SEARCH: begin
				ram_re = srch_res.done && srch_res.found;
			end
			ST_MAP: begin
			end
			ST_FIN: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			depth_limit_q <= COORD_W'(630);
			geom_q.radius_squared <= RAD_W'(40000);
			geom_q.first_x <= COORD_W'(5500);
			geom_q.first_y <= COORD_W'(3800);
			geom_q.step_x <= STEP_W'(102400);
			geom_q.step_y <= -STEP_W'(102400);
			geom_q.cols_in_use <= GRID_W'(10);
			geom_q.rows_in_use <= GRID_W'(10);
			count_q <= '0;
			row_vld_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_DEPTH_LIMIT: depth_limit_q <= cfg_data[COORD_W-1:0];
					REG_RADIUS_SQ:   geom_q.radius_squared <= cfg_data[RAD_W-1:0];
					REG_FIRST_X:     geom_q.first_x <= cfg_data[COORD_W-1:0];
					REG_FIRST_Y:     geom_q.first_y <= cfg_data[COORD_W-1:0];
					REG_STEP_X:      geom_q.step_x <= cfg_data[STEP_W-1:0];
					REG_STEP_Y:      geom_q.step_y <= cfg_data[STEP_W-1:0];
					REG_COLS:        geom_q.cols_in_use <= cfg_data[GRID_W-1:0];
					REG_ROWS:        geom_q.rows_in_use <= cfg_data[GRID_W-1:0];
					default: begin
					end
				endcase
			end
			if (ram_we) begin
				row_vld_q[row_q] <= 1'b1;
				if (count_q != TOTAL_MAX) begin
					count_q <= count_q + TOTAL_W'(1);
				end
			end
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
				if (last_q) begin
					count_q <= '0;
					row_vld_q <= '0;
				end
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			prob_q <= in_prob;
			last_q <= s_axis_tlast;
			found_q <= 1'b0;
			fresh_q <= 1'b0;
			row_q <= '0;
			col_q <= '0;
		end
		if ((state_q == ST_SEARCH) && srch_res.done && srch_res.found) begin
			found_q <= 1'b1;
			row_q <= srch_res.row;
			col_q <= srch_res.col;
		end
		if (state_q == ST_MAP) begin
			fresh_q <= !bit_set;
		end
		if (out_load) begin
			m_axis_tdata <= {3'b000, count_q, POS_W'(col_q), POS_W'(row_q)};
			m_axis_tuser <= {fresh_q, found_q, prob_q};
			m_axis_tlast <= last_q;
		end
	end

	ddwm_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (srch_start),
		.px     (in_x),
		.py     (in_y),
		.geom   (geom_q),
		.res    (srch_res)
	);

	ddwm_ram #(
		.WIDTH (MAX_COLS),
		.DEPTH (MAX_ROWS)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_q),
		.wdata (row_new),
		.re    (ram_re),
		.raddr (srch_res.row),
		.rdata (ram_rdata)
	);

	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		srch_res.done |-> (state_q == ST_SEARCH))
		else $error("scan result arrived outside the search state");

	a_write_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ($past(ram_re) && (state_q == ST_MAP)))
		else $error("map write without a preceding map read");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after taking a word");

	a_cloud_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_q) |=> ((count_q == '0) && (row_vld_q == '0)))
		else $error("map not cleared after the last point of a cloud");

endmodule
`default_nettype wire

// ----- bench/depth_dip_waypoint_matcher_top_tb.sv -----
// Self-checking testbench for depth_dip_waypoint_matcher_top: random-gap point words in, one
// result word out per point, compared against a serpentine waypoint search held in the bench.
// Depends on ddwm_pkg and the depth_dip_waypoint_matcher_top RTL.
module depth_dip_waypoint_matcher_top_tb;
	import ddwm_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;

	typedef struct packed {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] z;
		logic               finite;
		logic               last;
	} point_t;

	typedef struct packed {
		logic        prob;
		logic        found;
		logic [4:0]  row;
		logic [4:0]  col;
		logic        fresh;
		logic [10:0] total;
		logic        done;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	logic signed [17:0] depth_lim;
	logic signed [17:0] org_x, org_y;
	logic signed [25:0] pitch_x, pitch_y;
	logic [26:0]        reach_sq;
	logic [5:0]         ncols_raw, nrows_raw;
	bit                 map_bits [0:MAX_ROWS*MAX_COLS-1];
	int                 map_total;

	point_t   points_to_send [$];
	outcome_t due_results [$];
	point_t   cur_point;
	int       send_hold = 0, send_calm = 0, recv_stall = 0, recv_calm = 0;
	int       fails = 0;
	int       quiet_cycles = 0;

	depth_dip_waypoint_matcher_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int span_of(logic [5:0] n, int cap);
		if (n == 0)
			return 1;
		if (n > cap)
			return cap;
		return int'(n);
	endfunction

	function automatic longint div256_round(longint p);
		if (p >= 0)
			return (p + 128) >>> 8;
		return -((-p + 128) >>> 8);
	endfunction

	function automatic longint waypoint_x(int c);
		return longint'(org_x) + div256_round(longint'(c) * longint'(pitch_x));
	endfunction

	function automatic longint waypoint_y(int r);
		return longint'(org_y) + div256_round(longint'(r) * longint'(pitch_y));
	endfunction

	function automatic int srand(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2)
			calm = $urandom_range(20, 60);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	// Serpentine search: even rows run up the columns, odd rows down.
	function automatic outcome_t match_point(point_t p);
		outcome_t o;
		int rows, cols, i, j, c, frow, fcol;
		longint dx, dy, dy2;
		o = '0;
		frow = 0;
		fcol = 0;
		o.prob = p.finite && (p.z < depth_lim);
		if (o.prob) begin
			rows = span_of(nrows_raw, MAX_ROWS);
			cols = span_of(ncols_raw, MAX_COLS);
			for (i = 0; i < rows && !o.found; i++) begin
				dy = longint'($signed(p.y)) - waypoint_y(i);
				dy2 = dy * dy;
				for (j = 0; j < cols && !o.found; j++) begin
					c = (i % 2 == 1) ? cols - 1 - j : j;
					dx = longint'($signed(p.x)) - waypoint_x(c);
					if (dx * dx + dy2 <= longint'(reach_sq)) begin
						o.found = 1'b1;
						frow = i;
						fcol = c;
					end
				end
			end
			if (o.found) begin
				o.row = 5'(frow);
				o.col = 5'(fcol);
				if (!map_bits[frow * MAX_COLS + fcol]) begin
					map_bits[frow * MAX_COLS + fcol] = 1'b1;
					map_total++;
					o.fresh = 1'b1;
				end
			end
		end
		o.total = 11'(map_total);
		o.done = p.last;
		if (p.last) begin
			map_bits = '{default: 0};
			map_total = 0;
		end
		return o;
	endfunction

	function automatic point_t make_point();
		point_t p;
		int kind, reach, r, c;
		longint px, py, pz;
		kind = $urandom_range(0, 99);
		reach = $rtoi($sqrt(real'(reach_sq))) + 2;
		r = $urandom_range(0, span_of(nrows_raw, MAX_ROWS) - 1);
		c = $urandom_range(0, span_of(ncols_raw, MAX_COLS) - 1);
		px = waypoint_x(c);
		py = waypoint_y(r);
		if ($urandom_range(0, 4) != 0) begin
			px += srand(-reach, reach);
			py += srand(-reach, reach);
		end
		pz = longint'(depth_lim) - 1 - $urandom_range(0, 3000);
		p.finite = 1'b1;
		p.last = 1'b0;
		if (kind >= 75 && kind < 85) begin
			px = $urandom();
			py = $urandom();
			pz = $urandom();
			p.finite = $urandom_range(0, 1);
		end else if (kind >= 85 && kind < 93) begin
			pz = longint'(depth_lim) + $urandom_range(0, 1);
		end else if (kind >= 93) begin
			p.finite = 1'b0;
		end
		p.x = px[17:0];
		p.y = py[17:0];
		p.z = pz[17:0];
		return p;
	endfunction

	task automatic push_point(input int x, input int y, input int z, input bit fin, input bit lst);
		point_t p;
		p.x = 18'(x);
		p.y = 18'(y);
		p.z = 18'(z);
		p.finite = fin;
		p.last = lst;
		points_to_send.insert(points_to_send.size(), p);
	endtask

	task automatic add_clouds(input int n);
		int k, len, m;
		point_t p;
		k = 0;
		while (k < n) begin
			len = $urandom_range(1, 16);
			if (len > n - k)
				len = n - k;
			for (m = 0; m < len; m++) begin
				p = make_point();
				p.last = (m == len - 1);
				if ($urandom_range(0, 19) == 0)
					p.last = $urandom_range(0, 1);
				points_to_send.insert(points_to_send.size(), p);
			end
			k += len;
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input longint v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[CFG_W-1:0];
		case (idx)
			REG_DEPTH_LIMIT: depth_lim = v[17:0];
			REG_RADIUS_SQ:   reach_sq = v[26:0];
			REG_FIRST_X:     org_x = v[17:0];
			REG_FIRST_Y:     org_y = v[17:0];
			REG_STEP_X:      pitch_x = v[25:0];
			REG_STEP_Y:      pitch_y = v[25:0];
			REG_COLS:        ncols_raw = v[5:0];
			REG_ROWS:        nrows_raw = v[5:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input int lim, input int r2, input int fx, input int fy,
			input int sx, input int sy, input int ncols, input int nrows);
		write_reg(REG_DEPTH_LIMIT, lim);
		write_reg(REG_RADIUS_SQ, r2);
		write_reg(REG_FIRST_X, fx);
		write_reg(REG_FIRST_Y, fy);
		write_reg(REG_STEP_X, sx);
		write_reg(REG_STEP_Y, sy);
		write_reg(REG_COLS, ncols);
		write_reg(REG_ROWS, nrows);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (points_to_send.size() != 0 || s_axis_tvalid || due_results.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				due_results.insert(due_results.size(), match_point(cur_point));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_hold > 0) begin
					send_hold--;
					s_axis_tvalid <= 1'b0;
				end else if (points_to_send.size() != 0) begin
					cur_point = points_to_send.pop_front();
					s_axis_tdata <= {2'b00, cur_point.z, cur_point.y, cur_point.x};
					s_axis_tuser <= cur_point.finite;
					s_axis_tlast <= cur_point.last;
					s_axis_tvalid <= 1'b1;
					send_hold = idle_len(send_calm);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with none due, expected nothing, actual %h/%h/%b",
						$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
					fails++;
				end else begin
					want = due_results.pop_front();
					check_field("problematic", want.prob, m_axis_tuser[0]);
					check_field("match_found", want.found, m_axis_tuser[1]);
					check_field("newly_matched", want.fresh, m_axis_tuser[2]);
					check_field("match_row", want.row, m_axis_tdata[4:0]);
					check_field("match_col", want.col, m_axis_tdata[9:5]);
					check_field("matched_total", want.total, m_axis_tdata[20:10]);
					check_field("cloud_done", want.done, m_axis_tlast);
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				recv_stall = idle_len(recv_calm);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int g;
		depth_lim = 18'sd630;
		reach_sq = 27'd40000;
		org_x = 18'sd5500;
		org_y = 18'sd3800;
		pitch_x = 26'sd102400;
		pitch_y = -26'sd102400;
		ncols_raw = 6'd10;
		nrows_raw = 6'd10;
		map_bits = '{default: 0};
		map_total = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset geometry: waypoint (r, c) sits at (5500 + 400c, 3800 - 400r), radius 200.
		push_point(5500, 3800, 0, 1, 0);
		push_point(5500, 3800, 0, 1, 0);
		push_point(5500, 3800, 630, 1, 0);
		push_point(9100, 3400, 629, 1, 0);
		push_point(5500, 3800, -100000, 0, 0);
		push_point(-100000, -100000, -100000, 1, 0);
		push_point(100000, 100000, 100000, 1, 0);
		push_point(5500, 4000, 0, 1, 0);
		push_point(5500, 4001, 0, 1, 0);
		push_point(5500, 200, 0, 1, 1);
		push_point(5500, 3800, 0, 1, 0);
		push_point(5700, 3800, 0, 1, 0);
		push_point(5700, 3400, 0, 1, 0);
		push_point(9500, 3800, 0, 1, 0);
		push_point(-131072, 131071, -131072, 1, 0);
		push_point(131071, -131072, 131071, 1, 1);
		add_clouds(60);
		wait_quiet();

		set_geometry(100000, 90000, -100000, -100000, 25600000, 25600000, 0, 0);
		add_clouds(60);
		wait_quiet();
		set_geometry(-100000, 250000, 100000, 100000, -25600000, -25600000, 2, 3);
		add_clouds(30);
		wait_quiet();
		set_geometry(0, 10000, 100000, -100000, -51200, 76800, 63, 63);
		add_clouds(80);
		wait_quiet();
		set_geometry(5000, 0, 0, 0, 12345, -99999, 7, 5);
		add_clouds(70);
		wait_quiet();
		set_geometry(-1, 100000000, 0, 0, -512000, 768000, 4, 3);
		add_clouds(70);
		wait_quiet();

		for (g = 0; g < 4; g++) begin
			set_geometry(srand(-100000, 100000),
				($urandom_range(0, 3) == 0) ? srand(0, 100000000) : srand(0, 40000),
				srand(-100000, 100000), srand(-100000, 100000),
				($urandom_range(0, 3) == 0) ? srand(-25600000, 25600000) : srand(-204800, 204800),
				($urandom_range(0, 3) == 0) ? srand(-25600000, 25600000) : srand(-204800, 204800),
				($urandom_range(0, 4) == 0) ? srand(0, 63) : srand(1, 12),
				($urandom_range(0, 4) == 0) ? srand(0, 63) : srand(1, 12));
			add_clouds(50);
			wait_quiet();
		end

		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
